@@ hdl/frequent_port_tracker_assert.svh @@
// Assertion macros for the frequent port tracker.
`ifndef FREQUENT_PORT_TRACKER_ASSERT_SVH
`define FREQUENT_PORT_TRACKER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FPT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frequent_port_tracker: assertion failed");

// Next-cycle implication, checked out of reset.
`define FPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frequent_port_tracker: assertion failed");

`endif

@@ hdl/fpt_pkg.sv @@
// Shared constants, codes and link types of the frequent port tracker.
package fpt_pkg;

  localparam int ENTRIES        = 8;
  localparam int COUNT_BITS     = 32;
  localparam int IDX_BITS       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PORT_BITS      = 16;
  localparam int KIND_BITS      = 2;
  localparam int SLOT_BITS      = 3;
  localparam int STATUS_BITS    = 3;
  localparam int COUNT_OUT_BITS = 32;

  localparam logic [KIND_BITS-1:0] KIND_OBSERVE = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_READ    = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_CLEAR   = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_NONE    = 2'd3;

  localparam logic [STATUS_BITS-1:0] STATUS_INC   = 3'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_INS   = 3'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_DEC   = 3'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_READ  = 3'd3;
  localparam logic [STATUS_BITS-1:0] STATUS_CLEAR = 3'd4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic                  eval;
    logic                  apply;
    logic [KIND_BITS-1:0]  kind;
    logic [PORT_BITS-1:0]  port;
    logic [SLOT_BITS-1:0]  rd_slot;
    logic                  any_hit;
    logic                  any_free;
  } fpt_ctrl_t;

  typedef struct packed {
    logic                  hit;
    logic                  free;
    logic [IDX_BITS-1:0]   idx;
    logic [COUNT_BITS-1:0] count;
    logic [PORT_BITS-1:0]  port;
  } fpt_link_t;

endpackage

@@ hdl/frequent_port_tracker.sv @@
// Top level of the frequent port tracker: control, cell chain and result register.
//
// A heavy-hitter table of port numbers in a row of slot cells. Each beat has a
// compare step and an update step: in the compare step, every cell compares the
// observed port with its own entry and the chain ripples first-match and
// first-free through the row; in the update step, the chosen cell updates (or all
// counts step down or clear; a read changes nothing) and the touched slot's contents
// ripple out to the result register. A new beat is taken in the update step of the
// previous one; the update waits while a previous result is held and not taken.
// Reset clears all slots at once; no clearing pass is needed.
`include "frequent_port_tracker_assert.svh"

module frequent_port_tracker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [fpt_pkg::KIND_BITS-1:0]      kind_i,
  input  logic [fpt_pkg::PORT_BITS-1:0]      port_i,
  input  logic [fpt_pkg::SLOT_BITS-1:0]      slot_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [fpt_pkg::STATUS_BITS-1:0]    status_o,
  output logic [fpt_pkg::SLOT_BITS-1:0]      slot_used_o,
  output logic [fpt_pkg::COUNT_OUT_BITS-1:0] count_o,
  output logic [fpt_pkg::PORT_BITS-1:0]      port_held_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]                         state_q, state_d;
  logic [fpt_pkg::KIND_BITS-1:0]      kind_q, kind_d;
  logic [fpt_pkg::PORT_BITS-1:0]      port_q, port_d;
  logic [fpt_pkg::SLOT_BITS-1:0]      slot_q, slot_d;
  logic                               any_hit_q, any_hit_d;
  logic                               any_free_q, any_free_d;
  logic                               out_valid_q, out_valid_d;
  logic [fpt_pkg::STATUS_BITS-1:0]    status_q, status_d;
  logic [fpt_pkg::SLOT_BITS-1:0]      slot_used_q, slot_used_d;
  logic [fpt_pkg::COUNT_OUT_BITS-1:0] count_q, count_d;
  logic [fpt_pkg::PORT_BITS-1:0]      port_held_q, port_held_d;

  logic               accept, apply_fire, emit;
  fpt_pkg::fpt_ctrl_t ctrl;
  fpt_pkg::fpt_link_t link [fpt_pkg::ENTRIES+1];
  fpt_pkg::fpt_link_t tail;

  assign apply_fire = (state_q == ST_APPLY) &&
                      ((kind_q == fpt_pkg::KIND_NONE) || !out_valid_q || out_ready_i);
  assign emit       = apply_fire && (kind_q != fpt_pkg::KIND_NONE);
  assign in_ready_o = (state_q == ST_IDLE) || apply_fire;
  assign accept     = in_valid_i && in_ready_o;

  assign ctrl.eval     = (state_q == ST_EVAL);
  assign ctrl.apply    = apply_fire;
  assign ctrl.kind     = kind_q;
  assign ctrl.port     = port_q;
  assign ctrl.rd_slot  = slot_q;
  assign ctrl.any_hit  = any_hit_q;
  assign ctrl.any_free = any_free_q;

  assign link[0] = '0;

  for (genvar g = 0; g < fpt_pkg::ENTRIES; g++) begin : g_cell
    fpt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .cell_idx_i (fpt_pkg::IDX_BITS'(g)),
      .chain_i    (link[g]),
      .chain_o    (link[g+1])
    );
  end

  assign tail = link[fpt_pkg::ENTRIES];

  always_comb begin
    state_d = state_q;
    if (accept) begin
      state_d = ST_EVAL;
    end else begin
      unique case (state_q)
        ST_IDLE:  state_d = ST_IDLE;
        ST_EVAL:  state_d = ST_APPLY;
        ST_APPLY: state_d = apply_fire ? ST_IDLE : ST_APPLY;
        default:  state_d = ST_IDLE;
      endcase
    end
  end

  assign kind_d     = accept ? kind_i : kind_q;
  assign port_d     = accept ? port_i : port_q;
  assign slot_d     = accept ? slot_i : slot_q;
  assign any_hit_d  = ctrl.eval ? tail.hit  : any_hit_q;
  assign any_free_d = ctrl.eval ? tail.free : any_free_q;

  always_comb begin
    status_d    = status_q;
    slot_used_d = slot_used_q;
    count_d     = count_q;
    port_held_d = port_held_q;
    if (emit) begin
      count_d     = fpt_pkg::COUNT_OUT_BITS'(tail.count);
      port_held_d = tail.port;
      slot_used_d = '0;
      unique case (kind_q)
        fpt_pkg::KIND_OBSERVE: begin
          if (any_hit_q) begin
            status_d    = fpt_pkg::STATUS_INC;
            slot_used_d = fpt_pkg::SLOT_BITS'(tail.idx);
          end else if (any_free_q) begin
            status_d    = fpt_pkg::STATUS_INS;
            slot_used_d = fpt_pkg::SLOT_BITS'(tail.idx);
          end else begin
            status_d = fpt_pkg::STATUS_DEC;
          end
        end
        fpt_pkg::KIND_READ: begin
          status_d    = fpt_pkg::STATUS_READ;
          slot_used_d = slot_q;
        end
        default: status_d = fpt_pkg::STATUS_CLEAR;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    port_q      <= port_d;
    slot_q      <= slot_d;
    any_hit_q   <= any_hit_d;
    any_free_q  <= any_free_d;
    status_q    <= status_d;
    slot_used_q <= slot_used_d;
    count_q     <= count_d;
    port_held_q <= port_held_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_used_o = slot_used_q;
  assign count_o     = count_q;
  assign port_held_o = port_held_q;

  `FPT_ASSERT_NEXT(a_accept_to_eval, accept, state_q == ST_EVAL)
  `FPT_ASSERT_NEXT(a_eval_to_apply, state_q == ST_EVAL, state_q == ST_APPLY)
  `FPT_ASSERT_NEXT(a_insert_count_one,
                   emit && (kind_q == fpt_pkg::KIND_OBSERVE) && !any_hit_q && any_free_q,
                   (status_o == fpt_pkg::STATUS_INS) && (count_o == 1) &&
                   (port_held_o == $past(port_q)))
  `FPT_ASSERT_NEXT(a_read_slot_echo, emit && (kind_q == fpt_pkg::KIND_READ),
                   out_valid_o && (slot_used_o == $past(slot_q)))
  `FPT_ASSERT_SAME(a_bulk_zero,
                   out_valid_o && ((status_o == fpt_pkg::STATUS_DEC) ||
                                   (status_o == fpt_pkg::STATUS_CLEAR)),
                   (count_o == 0) && (port_held_o == 0) && (slot_used_o == 0))

endmodule

@@ hdl/fpt_cell.sv @@
// One table slot: port and count, with its link into the cell chain.
module fpt_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fpt_pkg::fpt_ctrl_t            ctrl_i,
  input  logic [fpt_pkg::IDX_BITS-1:0]  cell_idx_i,
  input  fpt_pkg::fpt_link_t            chain_i,
  output fpt_pkg::fpt_link_t            chain_o
);

  logic [fpt_pkg::PORT_BITS-1:0]  port_q, port_d, port_nx;
  logic [fpt_pkg::COUNT_BITS-1:0] count_q, count_d, count_nx;
  logic                           inc_q, inc_d;
  logic                           ins_q, ins_d;
  logic                           match, free, rd_sel, my_sel;

  assign free   = (count_q == '0);
  assign match  = !free && (port_q == ctrl_i.port);
  assign rd_sel = (32'(ctrl_i.rd_slot) == 32'(cell_idx_i));

  // capture first-match and first-free during compare
  assign inc_d = ctrl_i.eval ? (match && !chain_i.hit) : inc_q;
  assign ins_d = ctrl_i.eval ? (free && !chain_i.free) : ins_q;

  always_comb begin
    count_nx = count_q;
    port_nx  = port_q;
    my_sel   = 1'b0;
    case (ctrl_i.kind)
      fpt_pkg::KIND_OBSERVE: begin
        if (ctrl_i.any_hit) begin
          my_sel = inc_q;
          if (inc_q && (count_q != fpt_pkg::COUNT_MAX)) begin
            count_nx = count_q + 1'b1;
          end
        end else if (ctrl_i.any_free) begin
          my_sel = ins_q;
          if (ins_q) begin
            port_nx  = ctrl_i.port;
            count_nx = fpt_pkg::COUNT_BITS'(1);
          end
        end else begin
          count_nx = count_q - 1'b1;
        end
      end
      fpt_pkg::KIND_READ: begin
        my_sel = rd_sel;
      end
      fpt_pkg::KIND_CLEAR: begin
        count_nx = '0;
      end
      default: ;
    endcase
  end

  assign count_d = ctrl_i.apply ? count_nx : count_q;
  assign port_d  = ctrl_i.apply ? port_nx  : port_q;

  always_comb begin
    chain_o      = chain_i;
    chain_o.hit  = chain_i.hit  || match;
    chain_o.free = chain_i.free || free;
    if (my_sel) begin
      chain_o.idx   = cell_idx_i;
      chain_o.count = count_nx;
      chain_o.port  = port_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_q  <= '0;
      count_q <= '0;
    end else begin
      port_q  <= port_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inc_q <= inc_d;
    ins_q <= ins_d;
  end

endmodule
